FILE: src/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define MWUF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked at every edge, reset included
`define MWUF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/mwuf_pkg.sv
package mwuf_pkg;

  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 32;

  // configuration port
  localparam int CFG_W     = 6;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_CELL_ROWS = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_CELL_COLS = 1'd1;
  localparam logic [CFG_W-1:0] CELL_ROWS_RESET = 6'd16;
  localparam logic [CFG_W-1:0] CELL_COLS_RESET = 6'd16;

  // wide enough for a 6-bit register and a bound up to 1023
  localparam int CMP_W = 10;

  localparam int COORD_W = 5;
  localparam int WALL_W  = 6;

  localparam logic OP_EAST  = 1'b0;
  localparam logic OP_SOUTH = 1'b1;

  // grid size after clamping to the build bounds
  typedef struct packed {
    logic [CMP_W-1:0] rows;
    logic [CMP_W-1:0] cols;
  } cfg_t;

endpackage

FILE: src/mwuf_ram.sv
module mwuf_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/mwuf_core.sv
module mwuf_core #(
  parameter int MAX_ROWS = mwuf_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = mwuf_pkg::DEF_MAX_COLS,
  localparam int NCELLS  = MAX_ROWS * MAX_COLS,
  localparam int IDXW    = $clog2(NCELLS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mwuf_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         op_i,
  input  logic [mwuf_pkg::COORD_W-1:0] cell_row_i,
  input  logic [mwuf_pkg::COORD_W-1:0] cell_col_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         opened_o,
  output logic                         no_wall_o,
  output logic [mwuf_pkg::WALL_W-1:0]  wall_row_o,
  output logic [mwuf_pkg::WALL_W-1:0]  wall_col_o,
  output logic                         ram_we_o,
  output logic [IDXW-1:0]              ram_waddr_o,
  output logic [IDXW-1:0]              ram_wdata_o,
  output logic [IDXW-1:0]              ram_raddr_o,
  input  logic [IDXW-1:0]              ram_rdata_i
);

  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(NCELLS - 1);
  localparam logic [IDXW-1:0] COL_STEP = IDXW'(MAX_COLS);
  localparam int CW = mwuf_pkg::CMP_W;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_WALK_A = 5'b00100,
    ST_WALK_B = 5'b01000,
    ST_RESP   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [IDXW-1:0] clr_q, clr_d;
  logic [IDXW-1:0] x_q, x_d;
  logic [IDXW-1:0] ra_q, ra_d;
  logic [IDXW-1:0] there_q, there_d;
  logic res_opened_q, res_opened_d;
  logic res_no_wall_q, res_no_wall_d;
  logic [mwuf_pkg::WALL_W-1:0] res_row_q, res_row_d;
  logic [mwuf_pkg::WALL_W-1:0] res_col_q, res_col_d;
  logic out_valid_q, out_valid_d;
  logic out_opened_q, out_opened_d;
  logic out_no_wall_q, out_no_wall_d;
  logic [mwuf_pkg::WALL_W-1:0] out_row_q, out_row_d;
  logic [mwuf_pkg::WALL_W-1:0] out_col_q, out_col_d;

  logic [CW-1:0]   r_w, c_w;
  logic            flag;
  logic [IDXW-1:0] here, there;

  // edge and range check on the incoming cell
  always_comb begin
    r_w  = CW'(cell_row_i);
    c_w  = CW'(cell_col_i);
    flag = (r_w >= cfg_i.rows) || (c_w >= cfg_i.cols);
    if (op_i == mwuf_pkg::OP_EAST) begin
      flag = flag || (c_w + CW'(1) >= cfg_i.cols);
    end else begin
      flag = flag || (r_w + CW'(1) >= cfg_i.rows);
    end
  end

  assign here  = IDXW'(IDXW'(cell_row_i) * COL_STEP) + IDXW'(cell_col_i);
  assign there = (op_i == mwuf_pkg::OP_EAST) ? here + IDXW'(1) : here + COL_STEP;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    x_d           = x_q;
    ra_d          = ra_q;
    there_d       = there_q;
    res_opened_d  = res_opened_q;
    res_no_wall_d = res_no_wall_q;
    res_row_d     = res_row_q;
    res_col_d     = res_col_q;
    out_valid_d   = out_valid_q;
    out_opened_d  = out_opened_q;
    out_no_wall_d = out_no_wall_q;
    out_row_d     = out_row_q;
    out_col_d     = out_col_q;
    ram_we_o      = 1'b0;
    ram_waddr_o   = x_q;
    ram_wdata_o   = ra_q;
    ram_raddr_o   = x_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        // identity fill of the parent store after reset
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = clr_q;
        clr_d       = clr_q + IDXW'(1);
        if (clr_q == IDX_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (flag) begin
            res_opened_d  = 1'b0;
            res_no_wall_d = 1'b1;
            res_row_d     = '0;
            res_col_d     = '0;
            state_d       = ST_RESP;
          end else begin
            ram_raddr_o   = here;
            x_d           = here;
            there_d       = there;
            res_no_wall_d = 1'b0;
            res_row_d     = {cell_row_i, (op_i == mwuf_pkg::OP_SOUTH)};
            res_col_d     = {cell_col_i, (op_i == mwuf_pkg::OP_EAST)};
            state_d       = ST_WALK_A;
          end
        end
      end
      ST_WALK_A: begin
        // read data holds parent of x_q
        if (ram_rdata_i == x_q) begin
          ra_d        = x_q;
          x_d         = there_q;
          ram_raddr_o = there_q;
          state_d     = ST_WALK_B;
        end else begin
          x_d         = ram_rdata_i;
          ram_raddr_o = ram_rdata_i;
        end
      end
      ST_WALK_B: begin
        if (ram_rdata_i == x_q) begin
          // link neighbor root under the named cell's root
          res_opened_d = (x_q != ra_q);
          ram_we_o     = (x_q != ra_q);
          ram_waddr_o  = x_q;
          ram_wdata_o  = ra_q;
          state_d      = ST_RESP;
        end else begin
          x_d         = ram_rdata_i;
          ram_raddr_o = ram_rdata_i;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_opened_d  = res_opened_q;
          out_no_wall_d = res_no_wall_q;
          out_row_d     = res_row_q;
          out_col_d     = res_col_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q           <= x_d;
    ra_q          <= ra_d;
    there_q       <= there_d;
    res_opened_q  <= res_opened_d;
    res_no_wall_q <= res_no_wall_d;
    res_row_q     <= res_row_d;
    res_col_q     <= res_col_d;
    out_opened_q  <= out_opened_d;
    out_no_wall_q <= out_no_wall_d;
    out_row_q     <= out_row_d;
    out_col_q     <= out_col_d;
  end

  assign out_valid_o = out_valid_q;
  assign opened_o    = out_opened_q;
  assign no_wall_o   = out_no_wall_q;
  assign wall_row_o  = out_row_q;
  assign wall_col_o  = out_col_q;

endmodule

FILE: src/maze_wall_union_find.sv
// channel   dir  handshake                 payload
// in        in   in_valid_i / in_ready_o   op_i, cell_row_i, cell_col_i
// out       out  out_valid_o / out_ready_i opened_o, no_wall_o, wall_row_o, wall_col_o
// cfg       in   cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// a wall transaction walks the parent ram from each of its two cells up to the root;
// each step is one read of the parent ram. the next input is accepted only once the
// result has moved into the output register. a flagged item skips the walk and goes
// from its accept through ST_RESP to the output register.
// after reset the parent ram is filled with identity, one entry for each of the
// MAX_ROWS*MAX_COLS cells (1024 by default), with in_ready_o low; cfg writes are
// taken meanwhile.
// a result waiting on out_ready_i does not block the next input transaction; the result
// after it waits in the sequencer and holds in_ready_o low.
module maze_wall_union_find #(
  parameter int MAX_ROWS = mwuf_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = mwuf_pkg::DEF_MAX_COLS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mwuf_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [mwuf_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic [mwuf_pkg::COORD_W-1:0]   cell_row_i,
  input  logic [mwuf_pkg::COORD_W-1:0]   cell_col_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           opened_o,
  output logic                           no_wall_o,
  output logic [mwuf_pkg::WALL_W-1:0]    wall_row_o,
  output logic [mwuf_pkg::WALL_W-1:0]    wall_col_o
);

  localparam int NCELLS = MAX_ROWS * MAX_COLS;
  localparam int IDXW   = $clog2(NCELLS);
  localparam int CW     = mwuf_pkg::CMP_W;

  logic [mwuf_pkg::CFG_W-1:0] cell_rows_q, cell_rows_d;
  logic [mwuf_pkg::CFG_W-1:0] cell_cols_q, cell_cols_d;
  mwuf_pkg::cfg_t cfg;

  logic            ram_we;
  logic [IDXW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  always_comb begin
    cell_rows_d = cell_rows_q;
    cell_cols_d = cell_cols_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mwuf_pkg::REG_CELL_ROWS: cell_rows_d = cfg_data_i;
        mwuf_pkg::REG_CELL_COLS: cell_cols_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_rows_q <= mwuf_pkg::CELL_ROWS_RESET;
      cell_cols_q <= mwuf_pkg::CELL_COLS_RESET;
    end else begin
      cell_rows_q <= cell_rows_d;
      cell_cols_q <= cell_cols_d;
    end
  end

  // clamp to the build bounds
  assign cfg.rows = (CW'(cell_rows_q) > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(cell_rows_q);
  assign cfg.cols = (CW'(cell_cols_q) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cell_cols_q);

  mwuf_core #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .cell_row_i  (cell_row_i),
    .cell_col_i  (cell_col_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .opened_o    (opened_o),
    .no_wall_o   (no_wall_o),
    .wall_row_o  (wall_row_o),
    .wall_col_o  (wall_col_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  mwuf_ram #(
    .WIDTH (IDXW),
    .DEPTH (NCELLS)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: src/mwuf_checker.sv
`include "assert_macros.svh"

module mwuf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         opened_o,
  input logic                         no_wall_o,
  input logic [mwuf_pkg::WALL_W-1:0]  wall_row_o,
  input logic [mwuf_pkg::WALL_W-1:0]  wall_col_o
);

  `MWUF_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> (!in_ready_o && !out_valid_o), "busy in reset")

  // one transaction at a time in the sequencer
  `MWUF_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")

  `MWUF_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable({opened_o, no_wall_o, wall_row_o, wall_col_o})), "stalled result changed")

  `MWUF_ASSERT(a_flag_fixed, clk_i, rst_ni, (out_valid_o && no_wall_o) |-> (!opened_o && wall_row_o == '0 && wall_col_o == '0), "flagged result not cleared")

  // east wall sits at even row odd col, south wall the other way
  `MWUF_ASSERT(a_wall_parity, clk_i, rst_ni, (out_valid_o && !no_wall_o) |-> (wall_row_o[0] != wall_col_o[0]), "wall spot parity")

endmodule

bind maze_wall_union_find mwuf_checker u_checker (.*);
